FILE: src/ubx_fpe_pkg.sv
package ubx_fpe_pkg;

  // header layout: sync a, sync b, class, id, length low, length high
  localparam int unsigned HDR_LEN = 6;
  localparam int unsigned STORE_SIZE = 1024;

  localparam logic [7:0] SYNC_A = 8'hB5;
  localparam logic [7:0] SYNC_B = 8'h62;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_SELECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SELECT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  CLASS_SELECT_RST  = 8'd1;
  localparam logic [7:0]  ID_SELECT_RST     = 8'd7;
  localparam logic [15:0] RECORD_LENGTH_RST = 16'd92;

  typedef logic [7:0] byte_t;

endpackage

FILE: src/ubx_frame_payload_extractor.sv
// ubx_frame_payload_extractor
//
// receive bytes arrive on the in_ stream, one item per byte. the block hunts
// for a six-byte frame header (sync pair b5 62, class, id, little-endian
// length). a header whose class and id match cfg registers 0 and 1 and whose
// length plus six fits the store size opens a delivery run: the next
// min(length, record_length) bytes leave on the out_ stream with their offset,
// tlast on the final one and tuser set when the run reached record_length.
// all other bytes (foreign payloads, surplus bytes, checksums) feed the hunt.
//
// throughput: one item per cycle while out_ does not stall, set by the single register
// stage between the window/counter logic and the output register. a delivered
// byte shows on out_ in the cycle after it is accepted.
// stall: the output register holds its item while out_tready is low; during a
// delivery run in_tready then drops, while hunting bytes are still taken.
// reset (rst_n low, synchronous): window empty, hunting, no item pending,
// registers back to class 1, id 7, record length 92.
// configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge; index 3 is ignored.
module ubx_frame_payload_extractor
  import ubx_fpe_pkg::*;
#(
  // largest frame, header included, that the store takes
  parameter int unsigned STORE_BYTES = STORE_SIZE
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] payload_byte, [23:8] payload_index
  output logic                  out_tlast,  // last
  output logic                  out_tuser,  // [0] record_full
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0]  LAST_SLOT = 3'(HDR_LEN - 1);
  localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

  // configuration registers
  logic [7:0]  class_sel_r;
  logic [7:0]  id_sel_r;
  logic [15:0] rec_len_r;

  // hunt window and delivery state
  byte_t       win_r   [HDR_LEN];
  byte_t       win_nxt [HDR_LEN];
  byte_t       win_new [HDR_LEN];
  logic [2:0]  fill_r, fill_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic [15:0] to_deliver_r, to_deliver_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic        full_r, full_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_idx_r;
  logic        out_last_r;
  logic        out_full_r;

  logic        accept;
  logic        out_free;
  logic        is_last;
  logic [15:0] hdr_len;
  logic [15:0] run_len;
  logic        hdr_ok;
  logic        hdr_match;

  assign out_free  = !out_valid_r || out_tready;
  // hunting bytes never produce an item, so they need no room downstream
  assign in_tready = !in_pay_r || out_free;
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_full_r;

  assign is_last = ({1'b0, idx_r} + 17'd1) >= {1'b0, to_deliver_r};

  // window with the new byte dropped into the next free slot
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      win_new[i] = (fill_r == 3'(i)) ? in_tdata : win_r[i];
    end
  end

  assign hdr_len   = {win_new[5], win_new[4]};
  assign hdr_ok    = (win_new[0] == SYNC_A) && (win_new[1] == SYNC_B) &&
                     (({1'b0, hdr_len} + 17'(HDR_LEN)) <= STORE_LIM);
  assign hdr_match = (win_new[2] == class_sel_r) && (win_new[3] == id_sel_r);
  assign run_len   = (hdr_len < rec_len_r) ? hdr_len : rec_len_r;

  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    in_pay_nxt     = in_pay_r;
    to_deliver_nxt = to_deliver_r;
    idx_nxt        = idx_r;
    full_nxt       = full_r;
    if (accept) begin
      if (in_pay_r) begin
        if (is_last) begin
          in_pay_nxt     = 1'b0;
          idx_nxt        = '0;
          to_deliver_nxt = '0;
          full_nxt       = 1'b0;
        end else begin
          idx_nxt = idx_r + 16'd1;
        end
      end else if (fill_r != LAST_SLOT) begin
        win_nxt  = win_new;
        fill_nxt = fill_r + 3'd1;
      end else if (!hdr_ok) begin
        // drop the oldest byte and keep hunting
        for (int i = 0; i < HDR_LEN - 1; i++) begin
          win_nxt[i] = win_new[i+1];
        end
        win_nxt[HDR_LEN-1] = '0;
        fill_nxt           = LAST_SLOT;
      end else begin
        // good header empties the window
        for (int i = 0; i < HDR_LEN; i++) begin
          win_nxt[i] = '0;
        end
        fill_nxt = '0;
        if (hdr_match && (run_len != 16'd0)) begin
          in_pay_nxt     = 1'b1;
          to_deliver_nxt = run_len;
          idx_nxt        = '0;
          full_nxt       = (run_len == rec_len_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        win_r[i] <= '0;
      end
      fill_r       <= '0;
      in_pay_r     <= 1'b0;
      to_deliver_r <= '0;
      idx_r        <= '0;
      full_r       <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      fill_r       <= fill_nxt;
      in_pay_r     <= in_pay_nxt;
      to_deliver_r <= to_deliver_nxt;
      idx_r        <= idx_nxt;
      full_r       <= full_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_pay_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept && in_pay_r) begin
      out_byte_r <= in_tdata;
      out_idx_r  <= idx_r;
      out_last_r <= is_last;
      out_full_r <= is_last && full_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_sel_r <= CLASS_SELECT_RST;
      id_sel_r    <= ID_SELECT_RST;
      rec_len_r   <= RECORD_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_SELECT:  class_sel_r <= cfg_data[7:0];
        REG_ID_SELECT:     id_sel_r    <= cfg_data[7:0];
        REG_RECORD_LENGTH: rec_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
